// File: rtl/core/bale_pkg.sv
package bale_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT  = 3'd0,
        ACT_SEARCH  = 3'd1,
        ACT_DELETE  = 3'd2,
        ACT_SORT    = 3'd3,
        ACT_DISPLAY = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned FOUND_W = 5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;        // capture the incoming word
        logic    ins_write;   // append value at fill, bump fill
        logic    idx_clear;   // idx = 0
        logic    idx_pos;     // idx = position - 1
        logic    idx_inc;     // idx = idx + 1
        logic    rd_cur;      // read entry idx
        logic    rd_nxt;      // read entry idx + 1
        logic    wr_shift;    // write read data at idx, advance idx
        logic    fill_dec;    // drop one entry from the count
        logic    end_init;    // pass end = fill - 1
        logic    carry_load;  // carry = read data
        logic    sort_step;   // write min at idx, keep max, advance idx
        logic    sort_tail;   // write carry at pass end, shrink pass
        logic    emit;        // present a result word
        status_t emit_status;
        logic    emit_found;  // report idx + 1 as match position
        logic    emit_elem;   // report read data as element
        logic    emit_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             empty;
        logic             pos_bad;
        logic             match;
        logic             idx_lt_fill;
        logic             nxt_lt_fill;
        logic             idx_lt_end;
        logic             end_zero;
    } stat_t;

endpackage

// File: rtl/core/bale_ram.sv
module bale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bale_datapath.sv
module bale_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bale_pkg::cmd_t                       cmd,
    output bale_pkg::stat_t                      stat,
    input  logic [bale_pkg::ACT_W-1:0]           action,
    input  logic signed [bale_pkg::DATA_W-1:0]   value,
    input  logic [bale_pkg::POS_W-1:0]           position,
    output logic                                 result_valid,
    output logic [2:0]                           status,
    output logic [bale_pkg::FOUND_W-1:0]         found_position,
    output logic signed [bale_pkg::DATA_W-1:0]   element,
    output logic                                 last
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;

    logic [bale_pkg::ACT_W-1:0]         action_reg;
    logic signed [bale_pkg::DATA_W-1:0] value_reg;
    logic [bale_pkg::POS_W-1:0]         pos_reg;
    logic [CW-1:0]                      fill_reg, fill_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic [CW-1:0]                      end_reg, end_next;
    logic signed [bale_pkg::DATA_W-1:0] carry_reg, carry_next;

    logic                               valid_reg;
    logic [2:0]                         status_reg;
    logic [bale_pkg::FOUND_W-1:0]       found_reg;
    logic signed [bale_pkg::DATA_W-1:0] element_reg;
    logic                               last_reg;

    logic [CW-1:0]                      idx_plus;
    logic signed [bale_pkg::DATA_W-1:0] rdata;
    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [bale_pkg::DATA_W-1:0] wdata;
    logic                               re;
    logic [AW-1:0]                      raddr;
    logic                               greater;

    assign idx_plus = idx_reg + CW'(1);
    assign greater  = carry_reg > rdata;

    bale_ram #(
        .WIDTH (bale_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Memory port steering
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        if (cmd.ins_write)
        begin
            we    = 1'b1;
            waddr = fill_reg[AW-1:0];
            wdata = value_reg;
        end
        else if (cmd.wr_shift)
        begin
            we = 1'b1;
        end
        else if (cmd.sort_step)
        begin
            we    = 1'b1;
            wdata = greater ? rdata : carry_reg;
        end
        else if (cmd.sort_tail)
        begin
            we    = 1'b1;
            waddr = end_reg[AW-1:0];
            wdata = carry_reg;
        end
        re    = cmd.rd_cur | cmd.rd_nxt;
        raddr = cmd.rd_nxt ? idx_plus[AW-1:0] : idx_reg[AW-1:0];
    end

    always_comb
    begin
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        carry_next = carry_reg;
        if (cmd.ins_write)
        begin
            fill_next = fill_reg + CW'(1);
        end
        if (cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_pos)
        begin
            idx_next = CW'(PW'(pos_reg) - PW'(1));
        end
        else if (cmd.idx_inc || cmd.wr_shift || cmd.sort_step)
        begin
            idx_next = idx_plus;
        end
        if (cmd.end_init)
        begin
            end_next = (fill_reg == '0) ? '0 : fill_reg - CW'(1);
        end
        else if (cmd.sort_tail)
        begin
            end_next = end_reg - CW'(1);
        end
        if (cmd.carry_load)
        begin
            carry_next = rdata;
        end
        else if (cmd.sort_step && !greater)
        begin
            carry_next = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            value_reg  <= value;
            pos_reg    <= position;
        end
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        carry_reg <= carry_next;
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            found_reg   <= cmd.emit_found ? bale_pkg::FOUND_W'(idx_plus) : '0;
            element_reg <= cmd.emit_elem ? rdata : '0;
            last_reg    <= cmd.emit_last;
        end
    end

    always_comb
    begin
        stat.action      = action_reg;
        stat.full        = (fill_reg == CW'(CAPACITY));
        stat.empty       = (fill_reg == '0);
        stat.pos_bad     = (pos_reg == '0) || (PW'(pos_reg) > PW'(fill_reg));
        stat.match       = (rdata == value_reg);
        stat.idx_lt_fill = (idx_reg < fill_reg);
        stat.nxt_lt_fill = (idx_plus < fill_reg);
        stat.idx_lt_end  = (idx_reg < end_reg);
        stat.end_zero    = (end_reg == '0);
    end

    assign result_valid   = valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign element        = element_reg;
    assign last           = last_reg;

endmodule

// File: rtl/core/bale_ctrl.sv
module bale_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bale_pkg::stat_t stat,
    output bale_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DECODE = 12'b000000000010,
        S_SRD    = 12'b000000000100,
        S_SCMP   = 12'b000000001000,
        S_DRD    = 12'b000000010000,
        S_DWR    = 12'b000000100000,
        S_TPASS  = 12'b000001000000,
        S_TLD    = 12'b000010000000,
        S_TCARRY = 12'b000100000000,
        S_TRD    = 12'b001000000000,
        S_TSTEP  = 12'b010000000000,
        S_PRD    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pemit_reg, pemit_next;

    // Display alternates a read cycle and an emit cycle in S_PRD
    always_comb
    begin
        state_next = state_reg;
        pemit_next = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (bale_pkg::action_t'(stat.action))
                    bale_pkg::ACT_INSERT:
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (stat.full)
                        begin
                            cmd.emit_status = bale_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.ins_write   = 1'b1;
                            cmd.emit_status = bale_pkg::ST_OK;
                        end
                    end
                    bale_pkg::ACT_SEARCH:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_SRD;
                    end
                    bale_pkg::ACT_DELETE:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = bale_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.idx_pos = 1'b1;
                            state_next  = S_DRD;
                        end
                    end
                    bale_pkg::ACT_SORT:
                    begin
                        cmd.end_init = 1'b1;
                        state_next   = S_TPASS;
                    end
                    bale_pkg::ACT_DISPLAY:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = bale_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.idx_clear = 1'b1;
                            state_next    = S_PRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRD:
            begin
                if (stat.idx_lt_fill)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_SCMP;
                end
                else
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = bale_pkg::ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            S_SCMP:
            begin
                if (stat.match)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_found  = 1'b1;
                    cmd.emit_status = bale_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_DRD:
            begin
                if (stat.nxt_lt_fill)
                begin
                    cmd.rd_nxt = 1'b1;
                    state_next = S_DWR;
                end
                else
                begin
                    cmd.fill_dec    = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = bale_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_DWR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_DRD;
            end
            S_TPASS:
            begin
                if (stat.end_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = bale_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_TLD;
                end
            end
            S_TLD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_TCARRY;
            end
            S_TCARRY:
            begin
                cmd.carry_load = 1'b1;
                state_next     = S_TRD;
            end
            S_TRD:
            begin
                if (stat.idx_lt_end)
                begin
                    cmd.rd_nxt = 1'b1;
                    state_next = S_TSTEP;
                end
                else
                begin
                    cmd.sort_tail = 1'b1;
                    state_next    = S_TPASS;
                end
            end
            S_TSTEP:
            begin
                cmd.sort_step = 1'b1;
                state_next    = S_TRD;
            end
            S_PRD:
            begin
                if (!pemit_reg)
                begin
                    cmd.rd_cur = 1'b1;
                    pemit_next = 1'b1;
                end
                else
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_elem   = 1'b1;
                    cmd.emit_status = bale_pkg::ST_OK;
                    cmd.emit_last   = !stat.nxt_lt_fill;
                    if (stat.nxt_lt_fill)
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pemit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pemit_reg <= pemit_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/core/bounded_array_list_engine.sv
// Bounded list engine: holds up to CAPACITY signed 32-bit words plus a fill
// count and runs one operation per accepted command word (start high while
// busy is low). Search compares the entries in order until one matches,
// delete shifts every later entry down one place, display reads out each
// element in order, and sort runs bubble passes that each carry the largest
// remaining entry to the end of a shrinking pass. The list store is a single
// RAM with one write and one registered read port, which every step walks
// one entry at a time. Results come out on result_valid for exactly one
// cycle each and cannot be held off; a display emits one word per element
// with last on the final one, every other operation exactly one word. Action
// codes five to seven are dropped without a result. Entries beyond the fill
// count are never read, so the store needs no clearing after reset.
module bounded_array_list_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bale_pkg::ACT_W-1:0]         action,
    input  logic signed [bale_pkg::DATA_W-1:0] value,
    input  logic [bale_pkg::POS_W-1:0]         position,
    output logic                               result_valid,
    output logic [2:0]                         status,
    output logic [bale_pkg::FOUND_W-1:0]       found_position,
    output logic signed [bale_pkg::DATA_W-1:0] element,
    output logic                               last
);

    bale_pkg::cmd_t  cmd;
    bale_pkg::stat_t stat;

    // Sequencer: decodes the word and steps through the list walk
    bale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Store, counters, compare and the result register
    bale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .value          (value),
        .position       (position),
        .result_valid   (result_valid),
        .status         (status),
        .found_position (found_position),
        .element        (element),
        .last           (last)
    );

endmodule
